### hdl/cts_pkg.sv
// Shared types and constants of the tick scheduler.
package cts_pkg;

	localparam int SLOTS_DEF = 64;

	localparam logic [1:0] PH_NEW   = 2'd0;
	localparam logic [1:0] PH_READY = 2'd1;
	localparam logic [1:0] PH_RUN   = 2'd2;
	localparam logic [1:0] PH_TERM  = 2'd3;

	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_CREATE = 1'b1;

	localparam logic CFG_MODE  = 1'b0;
	localparam logic CFG_SLICE = 1'b1;

	localparam logic MODE_RR   = 1'b0;
	localparam logic MODE_PRIO = 1'b1;

	localparam logic [4:0] SLICE_RESET = 5'd3;
	localparam logic [4:0] SLICE_MIN   = 5'd1;
	localparam logic [4:0] SLICE_MAX   = 5'd20;

	typedef struct packed {
		logic [1:0]  phase;
		logic [7:0]  pid;
		logic [15:0] arrival;
		logic [15:0] left;
		logic [7:0]  prio;
		logic [15:0] wcnt;
	} rec_t;

	typedef struct packed {
		logic create;
		logic tick_begin;
		logic run_latch;
		logic sweep;
		logic post;
		logic disp_rd;
		logic disp;
	} cmd_t;

	typedef struct packed {
		logic run_valid;
		logic sweep_last;
		logic need_disp;
	} sts_t;

endpackage

### hdl/cts_ctrl.sv
// Sequencing state machine of the tick scheduler.
module cts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          func,
	input  cts_pkg::sts_t sts,
	output cts_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import cts_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RUNRD  = 3'd1;
	localparam logic [2:0] S_SWEEP  = 3'd2;
	localparam logic [2:0] S_POST   = 3'd3;
	localparam logic [2:0] S_DRD    = 3'd4;
	localparam logic [2:0] S_DISP   = 3'd5;
	localparam logic [2:0] S_RESULT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (func == FUNC_CREATE) begin
						cmd.create = 1'b1;
						state_nx   = S_RESULT;
					end else begin
						cmd.tick_begin = 1'b1;
						state_nx       = sts.run_valid ? S_RUNRD : S_SWEEP;
					end
				end
			end
			S_RUNRD: begin
				cmd.run_latch = 1'b1;
				state_nx      = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_nx = S_POST;
			end
			S_POST: begin
				cmd.post = 1'b1;
				state_nx = S_DRD;
			end
			S_DRD: begin
				if (sts.need_disp) begin
					cmd.disp_rd = 1'b1;
					state_nx    = S_DISP;
				end else begin
					state_nx = S_RESULT;
				end
			end
			S_DISP: begin
				cmd.disp = 1'b1;
				state_nx = S_RESULT;
			end
			S_RESULT: state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESULT);

endmodule

### hdl/cts_dpath.sv
// Slot table, scheduling registers and totals of the tick scheduler.
module cts_dpath #(
	parameter int SLOTS = cts_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cts_pkg::cmd_t cmd,
	output cts_pkg::sts_t sts,
	input  logic [5:0]    slot,
	input  logic [7:0]    pid,
	input  logic [15:0]   arrival,
	input  logic [15:0]   burst,
	input  logic [7:0]    prio,
	input  logic [15:0]   now,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [4:0]    cfg_data,
	output logic [7:0]    run_pid,
	output logic          idle,
	output logic          finished,
	output logic [7:0]    done_pid,
	output logic [15:0]   done_wait,
	output logic [15:0]   done_turnaround,
	output logic [15:0]   finished_total,
	output logic [31:0]   wait_sum,
	output logic [31:0]   turnaround_sum,
	output logic [31:0]   busy_count,
	output logic [31:0]   tick_count
);
	import cts_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	rec_t          mem_q [SLOTS];
	rec_t          rd_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	rec_t          wr_data;

	logic [SLOTS-1:0] act_q;
	logic          mode_q;
	logic [4:0]    tslice_q;
	logic [4:0]    slice_q;
	logic [IW-1:0] rptr_q;
	logic          run_valid_q;
	logic [IW-1:0] run_slot_q;
	logic          run_ok_q;
	rec_t          run_rec_q;
	logic [15:0]   now_q;
	logic [CW-1:0] cnt_q;
	logic          pv_s1;
	logic [IW-1:0] pidx_s1;
	logic          lo_v_q, hi_v_q, bst_v_q;
	logic [IW-1:0] lo_idx_q, hi_idx_q, bst_idx_q;
	logic [7:0]    bst_prio_q;
	logic [IW-1:0] cand_q;
	logic          need_disp_q;
	logic          ran_q;
	logic [7:0]    ran_pid_q;
	logic          fin_q;
	logic [7:0]    fin_pid_q;
	logic [15:0]   fin_wait_q, fin_turn_q, dcount_q;
	logic [31:0]   wsum_q, tsum_q, busy_q, ticks_q;

	// Create path.
	logic [7:0]    slot8;
	logic          slot_ok;
	rec_t          new_rec;

	// Sweep path.
	rec_t          sw_rec;
	logic          sw_ready;

	// Running process step.
	logic          r_done;
	logic [15:0]   r_left_dec;
	logic [4:0]    slice_dec;
	logic          higher;
	rec_t          p_rec;
	logic          p_complete, p_busy, p_rv, p_disp, p_r_ready;
	logic [4:0]    p_slice;
	logic          h_v, l_v, cand_v;
	logic [IW-1:0] h_i, l_i, cand_nx;

	// Dispatch.
	logic          d_done;
	rec_t          d_rec;
	logic [IW-1:0] rptr_nx;

	// Completion figures.
	logic          comp_en;
	rec_t          comp_rec;
	logic [16:0]   turn17;
	logic [15:0]   turn;
	logic [32:0]   wadd, tadd;
	logic          busy_inc;
	logic [4:0]    q_clamp;

	assign slot8   = {2'b00, slot};
	assign slot_ok = ({3'b000, slot} < 9'(SLOTS));
	always_comb begin
		new_rec         = '0;
		new_rec.phase   = PH_NEW;
		new_rec.pid     = pid;
		new_rec.arrival = arrival;
		new_rec.left    = burst;
		new_rec.prio    = prio;
		new_rec.wcnt    = '0;
	end

	always_comb begin
		sw_rec = rd_q;
		if (act_q[pidx_s1] && sw_rec.phase == PH_NEW && sw_rec.arrival <= now_q)
			sw_rec.phase = PH_READY;
		sw_ready = act_q[pidx_s1] && (sw_rec.phase == PH_READY);
		if (sw_ready && sw_rec.wcnt != 16'hFFFF) sw_rec.wcnt = sw_rec.wcnt + 16'd1;
	end

	assign r_done     = (run_rec_q.left <= 16'd1);
	assign r_left_dec = r_done ? 16'd0 : run_rec_q.left - 16'd1;
	assign slice_dec  = (slice_q != 5'd0) ? slice_q - 5'd1 : 5'd0;
	assign higher     = bst_v_q && (bst_prio_q < run_rec_q.prio);

	always_comb begin
		p_rec      = run_rec_q;
		p_rec.left = r_left_dec;
		p_complete = 1'b0;
		p_busy     = 1'b0;
		p_rv       = run_valid_q;
		p_disp     = 1'b1;
		p_r_ready  = 1'b0;
		p_slice    = slice_q;
		if (run_ok_q) begin
			if (r_done) begin
				p_rec.phase = PH_TERM;
				p_complete  = 1'b1;
				p_rv        = 1'b0;
				p_slice     = tslice_q;
			end else if (mode_q == MODE_RR) begin
				if (slice_dec == 5'd0) begin
					p_rec.phase = PH_READY;
					p_rv        = 1'b0;
					p_slice     = tslice_q;
					p_r_ready   = 1'b1;
				end else begin
					p_busy  = 1'b1;
					p_slice = slice_dec;
					p_disp  = 1'b0;
				end
			end else begin
				if (higher) begin
					p_rec.phase = PH_READY;
					p_rv        = 1'b0;
				end else begin
					p_busy = 1'b1;
					p_disp = 1'b0;
				end
			end
		end else if (run_valid_q) begin
			p_rv = 1'b0;
			if (mode_q == MODE_RR) p_slice = tslice_q;
		end
	end

	// Round robin: the first ready slot at or after the pointer, else the lowest one.
	// A process whose quantum just ran out rejoins the ready set here.
	always_comb begin
		h_v = hi_v_q;
		h_i = hi_idx_q;
		l_v = lo_v_q;
		l_i = lo_idx_q;
		if (p_r_ready) begin
			if (run_slot_q >= rptr_q && (!h_v || run_slot_q < h_i)) begin
				h_v = 1'b1;
				h_i = run_slot_q;
			end
			if (!l_v || run_slot_q < l_i) begin
				l_v = 1'b1;
				l_i = run_slot_q;
			end
		end
		if (mode_q == MODE_RR) begin
			cand_v  = h_v || l_v;
			cand_nx = h_v ? h_i : l_i;
		end else begin
			cand_v  = bst_v_q;
			cand_nx = bst_idx_q;
		end
	end

	assign d_done = (rd_q.left <= 16'd1);
	always_comb begin
		d_rec       = rd_q;
		d_rec.phase = d_done ? PH_TERM : PH_RUN;
		d_rec.left  = d_done ? 16'd0 : rd_q.left - 16'd1;
	end
	assign rptr_nx = (cand_q == IW'(SLOTS - 1)) ? '0 : cand_q + 1'b1;

	assign comp_en  = (cmd.post && run_ok_q && r_done) || (cmd.disp && d_done);
	assign comp_rec = cmd.disp ? rd_q : run_rec_q;
	assign turn17   = {1'b0, now_q} - {1'b0, comp_rec.arrival} + 17'd1;
	assign turn     = (now_q < comp_rec.arrival) ? 16'd0 :
		(turn17[16] ? 16'hFFFF : turn17[15:0]);
	assign wadd     = {1'b0, wsum_q} + {17'd0, comp_rec.wcnt};
	assign tadd     = {1'b0, tsum_q} + {17'd0, turn};
	assign busy_inc = (cmd.post && p_busy) || (cmd.disp && !d_done);

	assign q_clamp = (cfg_data < SLICE_MIN) ? SLICE_MIN :
		((cfg_data > SLICE_MAX) ? SLICE_MAX : cfg_data);

	// Memory port selection.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = run_slot_q;
		if (cmd.tick_begin) begin
			rd_en = 1'b1;
		end else if (cmd.sweep) begin
			rd_en   = (cnt_q < CW'(SLOTS));
			rd_addr = cnt_q[IW-1:0];
		end else if (cmd.disp_rd) begin
			rd_en   = 1'b1;
			rd_addr = cand_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pidx_s1;
		wr_data = sw_rec;
		priority if (cmd.create) begin
			wr_en   = slot_ok;
			wr_addr = slot8[IW-1:0];
			wr_data = new_rec;
		end else if (cmd.sweep) begin
			wr_en = pv_s1;
		end else if (cmd.post) begin
			wr_en   = run_ok_q;
			wr_addr = run_slot_q;
			wr_data = p_rec;
		end else if (cmd.disp) begin
			wr_en   = 1'b1;
			wr_addr = cand_q;
			wr_data = d_rec;
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem_q[rd_addr];
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.tick_begin) now_q <= now;
		if (cmd.run_latch) run_rec_q <= rd_q;
		if (cmd.sweep) pidx_s1 <= cnt_q[IW-1:0];
		if (cmd.post) cand_q <= cand_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= '0;
			mode_q      <= MODE_RR;
			tslice_q    <= SLICE_RESET;
			slice_q     <= SLICE_RESET;
			rptr_q      <= '0;
			run_valid_q <= 1'b0;
			run_slot_q  <= '0;
			run_ok_q    <= 1'b0;
			cnt_q       <= '0;
			pv_s1       <= 1'b0;
			lo_v_q      <= 1'b0;
			hi_v_q      <= 1'b0;
			bst_v_q     <= 1'b0;
			lo_idx_q    <= '0;
			hi_idx_q    <= '0;
			bst_idx_q   <= '0;
			bst_prio_q  <= '0;
			need_disp_q <= 1'b0;
			ran_q       <= 1'b0;
			ran_pid_q   <= '0;
			fin_q       <= 1'b0;
			fin_pid_q   <= '0;
			fin_wait_q  <= '0;
			fin_turn_q  <= '0;
			dcount_q    <= '0;
			wsum_q      <= '0;
			tsum_q      <= '0;
			busy_q      <= '0;
			ticks_q     <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MODE) begin
					mode_q  <= cfg_data[0];
					slice_q <= tslice_q;
				end else begin
					tslice_q <= q_clamp;
				end
			end
			if (cmd.create || cmd.tick_begin) begin
				ran_q      <= 1'b0;
				ran_pid_q  <= '0;
				fin_q      <= 1'b0;
				fin_pid_q  <= '0;
				fin_wait_q <= '0;
				fin_turn_q <= '0;
			end
			if (cmd.create && slot_ok) act_q[slot8[IW-1:0]] <= 1'b1;
			if (cmd.tick_begin) begin
				if (ticks_q != 32'hFFFF_FFFF) ticks_q <= ticks_q + 32'd1;
				cnt_q       <= '0;
				pv_s1       <= 1'b0;
				lo_v_q      <= 1'b0;
				hi_v_q      <= 1'b0;
				bst_v_q     <= 1'b0;
				run_ok_q    <= 1'b0;
				need_disp_q <= 1'b0;
			end
			if (cmd.run_latch) run_ok_q <= act_q[run_slot_q] && (rd_q.phase == PH_RUN);
			if (cmd.sweep) begin
				cnt_q <= cnt_q + 1'b1;
				pv_s1 <= (cnt_q < CW'(SLOTS));
				if (pv_s1 && sw_ready) begin
					if (!lo_v_q) begin
						lo_v_q   <= 1'b1;
						lo_idx_q <= pidx_s1;
					end
					if (!hi_v_q && pidx_s1 >= rptr_q) begin
						hi_v_q   <= 1'b1;
						hi_idx_q <= pidx_s1;
					end
					if (!bst_v_q || sw_rec.prio < bst_prio_q) begin
						bst_v_q    <= 1'b1;
						bst_idx_q  <= pidx_s1;
						bst_prio_q <= sw_rec.prio;
					end
				end
			end
			if (cmd.post) begin
				run_valid_q <= p_rv;
				slice_q     <= p_slice;
				need_disp_q <= p_disp && cand_v;
				if (run_ok_q) begin
					ran_q     <= 1'b1;
					ran_pid_q <= run_rec_q.pid;
				end
			end
			if (cmd.disp) begin
				run_valid_q <= !d_done;
				run_slot_q  <= cand_q;
				ran_q       <= 1'b1;
				ran_pid_q   <= rd_q.pid;
				if (mode_q == MODE_RR || d_done) slice_q <= tslice_q;
				if (mode_q == MODE_RR) rptr_q <= rptr_nx;
			end
			if (comp_en) begin
				fin_q      <= 1'b1;
				fin_pid_q  <= comp_rec.pid;
				fin_wait_q <= comp_rec.wcnt;
				fin_turn_q <= turn;
				if (dcount_q != 16'hFFFF) dcount_q <= dcount_q + 16'd1;
				wsum_q <= wadd[32] ? 32'hFFFF_FFFF : wadd[31:0];
				tsum_q <= tadd[32] ? 32'hFFFF_FFFF : tadd[31:0];
			end
			if (busy_inc && busy_q != 32'hFFFF_FFFF) busy_q <= busy_q + 32'd1;
		end
	end

	assign sts.run_valid  = run_valid_q;
	assign sts.sweep_last = (cnt_q == CW'(SLOTS));
	assign sts.need_disp  = need_disp_q;

	assign run_pid         = ran_pid_q;
	assign idle            = !ran_q;
	assign finished        = fin_q;
	assign done_pid        = fin_pid_q;
	assign done_wait       = fin_wait_q;
	assign done_turnaround = fin_turn_q;
	assign finished_total  = dcount_q;
	assign wait_sum        = wsum_q;
	assign turnaround_sum  = tsum_q;
	assign busy_count      = busy_q;
	assign tick_count      = ticks_q;

	// A process held as running always sits in a filled slot.
	a_run_active: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> act_q[run_slot_q]) else $error("running slot not active");

	// The tick counter never goes backward.
	a_ticks_mono: assert property (@(posedge clk) disable iff (!arst_n)
		ticks_q >= $past(ticks_q)) else $error("tick count decreased");

	// The quantum countdown never exceeds the largest quantum.
	a_slice_range: assert property (@(posedge clk) disable iff (!arst_n)
		slice_q <= SLICE_MAX) else $error("quantum countdown out of range");

endmodule

### hdl/cpu_tick_scheduler_rr_priority.sv
// Top level of the tick scheduler: controller and datapath.
//
// Tick scheduler over a table of SLOTS process slots. Raise start for one
// cycle while busy is low to hand in an item: func selects a create (fills
// a slot) or a tick (advances time to now and schedules by round robin or
// preemptive priority). Every item yields exactly one result, shown on the
// result ports for the single cycle in which done is high; the receiver
// cannot hold it off, so it must take it in that cycle. A create goes
// straight to the result state. The slot table is one memory with a
// registered read port; in a tick the admission, wait update and candidate
// search walk it one slot per cycle with a final step to drain the read,
// followed by a step for the running process and a dispatch decision. An
// extra step before the walk reads the running process's slot when a
// process was running, and another after the decision moves a newly
// dispatched process into its slot.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at once and
// are meant to happen only while busy is low. The totals on the result
// ports are the running figures after the item.
module cpu_tick_scheduler_rr_priority #(
	parameter int SLOTS = cts_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [5:0]  slot,
	input  logic [7:0]  pid,
	input  logic [15:0] arrival,
	input  logic [15:0] burst,
	input  logic [7:0]  prio,
	input  logic [15:0] now,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	output logic        done,
	output logic [7:0]  run_pid,
	output logic        idle,
	output logic        finished,
	output logic [7:0]  done_pid,
	output logic [15:0] done_wait,
	output logic [15:0] done_turnaround,
	output logic [15:0] finished_total,
	output logic [31:0] wait_sum,
	output logic [31:0] turnaround_sum,
	output logic [31:0] busy_count,
	output logic [31:0] tick_count
);
	import cts_pkg::*;

	// Command and status between the sequencer and the datapath.
	cmd_t cmd;
	sts_t sts;

	// The sequencer steps one item through its phases.
	cts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath owns the slot table, the scheduling state and the totals.
	cts_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.slot            (slot),
		.pid             (pid),
		.arrival         (arrival),
		.burst           (burst),
		.prio            (prio),
		.now             (now),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.run_pid         (run_pid),
		.idle            (idle),
		.finished        (finished),
		.done_pid        (done_pid),
		.done_wait       (done_wait),
		.done_turnaround (done_turnaround),
		.finished_total  (finished_total),
		.wait_sum        (wait_sum),
		.turnaround_sum  (turnaround_sum),
		.busy_count      (busy_count),
		.tick_count      (tick_count)
	);

endmodule
